// ===== hdl/safe_vector_normalize_3d_defines.svh =====
// Assertion macros shared by the safe vector normalizer RTL.
// Expects a clock named aclk and an active-low reset named aresetn in scope.
`ifndef SAFE_VECTOR_NORMALIZE_3D_DEFINES_SVH
`define SAFE_VECTOR_NORMALIZE_3D_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SVN_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SVN_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SVN_ASSERT_IMPLY(label, ante, cons)
`define SVN_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hdl/svn_pkg.sv =====
// Package for the safe 3D vector normalizer: formats, status codes, register map.
// No dependencies.
`default_nettype none
package svn_pkg;
    localparam int COMPONENT_WIDTH_DEF = 16;
    localparam int IN_FRAC = 12;
    localparam int OUT_FRAC = 14;
    localparam int OUT_W = 16;
    localparam int NSTEP = OUT_FRAC + 2;
    localparam int ROOT_SHIFT = 2 * OUT_FRAC + 2;
    localparam int ADDR_W = 3;
    localparam logic ADDR_IDX_TOLERANCE = 1'b0;
    localparam logic [31:0] TOLERANCE_RESET = 32'd1;

    typedef enum logic [1:0] {
        STATUS_NORM = 2'd0,
        STATUS_UNIT = 2'd1,
        STATUS_ZERO = 2'd2
    } status_t;
endpackage
`default_nettype wire

// ===== hdl/safe_vector_normalize_3d.sv =====
// Top level of the safe 3D vector normalizer: pipelined Q4.12 to Q1.14 normalization.
// Depends on svn_pkg and safe_vector_normalize_3d_defines.svh.
//
// Usage: input beats (s_x_in, s_y_in, s_z_in, signed Q4.12) enter on a valid/ready
// channel; result beats (m_x_out, m_y_out, m_z_out in signed Q1.14, and m_status)
// leave on a second valid/ready channel. Status 0 means normalized, 1 means the
// sum of squares was exactly one and the vector passed through, 2 means the sum
// was zero or below the tolerance register and the zero vector was returned.
// The tolerance register sits at APB byte address 0 and resets to 1.
// Throughput is one beat per cycle while m_ready does not stall the output; the
// pipeline holds three front stages (magnitude, square, sum and classify), then one
// stage per result bit of a 16-step shift-and-add search for the scaled inverse
// root, then the output register. The search stages set the latency.
// When the receiver holds m_ready low with a result waiting, the whole pipeline
// freezes and s_ready drops; nothing is lost or repeated. Reset empties the pipe.
`default_nettype none
`include "safe_vector_normalize_3d_defines.svh"
module safe_vector_normalize_3d #(
    parameter int COMPONENT_WIDTH = svn_pkg::COMPONENT_WIDTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [svn_pkg::ADDR_W-1:0]        paddr,
    input  wire logic [31:0]                       pwdata,
    output logic      [31:0]                       prdata,
    output logic                                   pready,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic signed [COMPONENT_WIDTH-1:0] s_x_in,
    input  wire logic signed [COMPONENT_WIDTH-1:0] s_y_in,
    input  wire logic signed [COMPONENT_WIDTH-1:0] s_z_in,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [svn_pkg::OUT_W-1:0]       m_x_out,
    output logic signed [svn_pkg::OUT_W-1:0]       m_y_out,
    output logic signed [svn_pkg::OUT_W-1:0]       m_z_out,
    output logic [1:0]                             m_status
);
    localparam int W = COMPONENT_WIDTH;
    localparam int SW = (2 * W + 2 > 34) ? 2 * W + 2 : 34;
    localparam int PW = SW + 32;
    localparam int NS = svn_pkg::NSTEP;
    localparam int OW = svn_pkg::OUT_W;
    localparam logic [SW-1:0] UNIT_SUM = SW'(1) << (2 * svn_pkg::IN_FRAC);

    logic [31:0] tolerance_reg;
    logic        en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tolerance_reg <= svn_pkg::TOLERANCE_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == svn_pkg::ADDR_IDX_TOLERANCE) begin
            tolerance_reg <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == svn_pkg::ADDR_IDX_TOLERANCE) ? tolerance_reg : 32'd0;

    assign en = !m_valid || m_ready;
    assign s_ready = en;

    logic signed [W-1:0] comp_in [3];
    assign comp_in[0] = s_x_in;
    assign comp_in[1] = s_y_in;
    assign comp_in[2] = s_z_in;

    // Front stages: magnitude, square.
    logic           va_reg, vb_reg;
    logic [W-1:0]   mag_a_reg [3];
    logic           sgn_a_reg [3];
    logic [2*W-1:0] sq_b_reg  [3];
    logic [W-1:0]   mag_b_reg [3];
    logic           sgn_b_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else if (en) begin
            va_reg <= s_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                sgn_a_reg[l] <= comp_in[l][W-1];
                mag_a_reg[l] <= comp_in[l][W-1] ? W'(-comp_in[l]) : W'(comp_in[l]);
                sq_b_reg[l]  <= (2*W)'(mag_a_reg[l]) * (2*W)'(mag_a_reg[l]);
                mag_b_reg[l] <= mag_a_reg[l];
                sgn_b_reg[l] <= sgn_a_reg[l];
            end
        end
    end

    // Search stages, index 0 holds the classified sum.
    logic                    v_it_reg    [0:NS];
    logic [SW-1:0]           s_it_reg    [0:NS];
    svn_pkg::status_t        st_it_reg   [0:NS];
    logic [PW-1:0]           r_it_reg    [0:NS][3];
    logic [PW-1:0]           p_it_reg    [0:NS][3];
    logic [PW-1:0]           q_it_reg    [0:NS][3];
    logic [NS-1:0]           m_it_reg    [0:NS][3];
    logic                    sgn_it_reg  [0:NS][3];
    logic [OW-1:0]           pass_it_reg [0:NS][3];

    logic [SW-1:0]    s_next;
    svn_pkg::status_t st_next;

    always_comb begin
        s_next = SW'(sq_b_reg[0]) + SW'(sq_b_reg[1]) + SW'(sq_b_reg[2]);
        if (s_next == UNIT_SUM) begin
            st_next = svn_pkg::STATUS_UNIT;
        end else if (s_next == '0 || s_next < SW'(tolerance_reg)) begin
            st_next = svn_pkg::STATUS_ZERO;
        end else begin
            st_next = svn_pkg::STATUS_NORM;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_it_reg[0] <= 1'b0;
        end else if (en) begin
            v_it_reg[0] <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s_it_reg[0]  <= s_next;
            st_it_reg[0] <= st_next;
            for (int l = 0; l < 3; l++) begin
                r_it_reg[0][l]    <= PW'(sq_b_reg[l]) << svn_pkg::ROOT_SHIFT;
                p_it_reg[0][l]    <= '0;
                q_it_reg[0][l]    <= '0;
                m_it_reg[0][l]    <= '0;
                sgn_it_reg[0][l]  <= sgn_b_reg[l];
                pass_it_reg[0][l] <= OW'({mag_b_reg[l], 2'b00});
            end
        end
    end

    for (genvar j = 0; j < NS; j++) begin : g_step
        localparam int K = NS - 1 - j;
        logic [PW-1:0] p_next [3];
        logic          take   [3];

        always_comb begin
            for (int l = 0; l < 3; l++) begin
                p_next[l] = p_it_reg[j][l] + (q_it_reg[j][l] << (K + 1))
                            + (PW'(s_it_reg[j]) << (2 * K));
                take[l] = p_next[l] <= r_it_reg[j][l];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_it_reg[j+1] <= 1'b0;
            end else if (en) begin
                v_it_reg[j+1] <= v_it_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                s_it_reg[j+1]  <= s_it_reg[j];
                st_it_reg[j+1] <= st_it_reg[j];
                for (int l = 0; l < 3; l++) begin
                    r_it_reg[j+1][l]    <= r_it_reg[j][l];
                    sgn_it_reg[j+1][l]  <= sgn_it_reg[j][l];
                    pass_it_reg[j+1][l] <= pass_it_reg[j][l];
                    if (take[l]) begin
                        p_it_reg[j+1][l] <= p_next[l];
                        q_it_reg[j+1][l] <= q_it_reg[j][l] + (PW'(s_it_reg[j]) << K);
                        m_it_reg[j+1][l] <= m_it_reg[j][l] | (NS'(1) << K);
                    end else begin
                        p_it_reg[j+1][l] <= p_it_reg[j][l];
                        q_it_reg[j+1][l] <= q_it_reg[j][l];
                        m_it_reg[j+1][l] <= m_it_reg[j][l];
                    end
                end
            end
        end
    end

    // Output register.
    logic              m_valid_reg;
    logic [OW-1:0]     out_reg  [3];
    logic [OW-1:0]     out_next [3];
    svn_pkg::status_t  status_reg;

    always_comb begin
        logic [NS:0]   n_full;
        logic [OW-1:0] mag_sel;
        for (int l = 0; l < 3; l++) begin
            n_full = ({1'b0, m_it_reg[NS][l]} + (NS+1)'(1)) >> 1;
            case (st_it_reg[NS])
                svn_pkg::STATUS_UNIT: mag_sel = pass_it_reg[NS][l];
                svn_pkg::STATUS_ZERO: mag_sel = '0;
                default:              mag_sel = OW'(n_full);
            endcase
            out_next[l] = sgn_it_reg[NS][l] ? OW'(0) - mag_sel : mag_sel;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= v_it_reg[NS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            status_reg <= st_it_reg[NS];
            for (int l = 0; l < 3; l++) begin
                out_reg[l] <= out_next[l];
            end
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_x_out  = out_reg[0];
    assign m_y_out  = out_reg[1];
    assign m_z_out  = out_reg[2];
    assign m_status = status_reg;

    `SVN_ASSERT_IMPLY(a_zero_vec, m_valid && m_status == svn_pkg::STATUS_ZERO,
        m_x_out == '0 && m_y_out == '0 && m_z_out == '0)
    `SVN_ASSERT_IMPLY(a_norm_range, m_valid && m_status == svn_pkg::STATUS_NORM,
        m_x_out >= -16'sd16384 && m_x_out <= 16'sd16384
        && m_y_out >= -16'sd16384 && m_y_out <= 16'sd16384
        && m_z_out >= -16'sd16384 && m_z_out <= 16'sd16384)
    `SVN_ASSERT_IMPLY(a_unit_lsbs, m_valid && m_status == svn_pkg::STATUS_UNIT,
        m_x_out[1:0] == 2'b00 && m_y_out[1:0] == 2'b00 && m_z_out[1:0] == 2'b00)
    `SVN_ASSERT_NEXT(a_stall_freeze, !en, $stable(v_it_reg[NS]) && $stable(va_reg))
endmodule
`default_nettype wire

// ===== bench/tb_safe_vector_normalize_3d.sv =====
// Testbench for safe_vector_normalize_3d: drives vector beats and APB writes,
// predicts each result in a scoreboard class and checks every output beat.
// Depends on svn_pkg and the safe_vector_normalize_3d RTL.
`timescale 1ns / 100ps

class norm_scoreboard;
    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic [1:0]  status;
    } norm_result_t;

    norm_result_t pending[$];
    logic [31:0]  tolerance;
    int           errors;

    function new();
        tolerance = svn_pkg::TOLERANCE_RESET;
        errors = 0;
    endfunction

    // Largest n with (2n-1)^2 * s <= a^2 * 2^30, which is round(a*2^14/sqrt(s)).
    function logic [15:0] scaled_mag(longint unsigned a, longint unsigned s);
        longint unsigned lo, hi, mid, t, rhs;
        lo = 0;
        hi = 16384;
        rhs = (a * a) << svn_pkg::ROOT_SHIFT;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            t = 2 * mid - 1;
            if (t * t * s <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return lo[15:0];
    endfunction

    function logic [15:0] signed_out(logic signed [15:0] c, logic [15:0] n);
        return (c < 0) ? 16'(-n) : n;
    endfunction

    function void note_vector(logic signed [15:0] x, logic signed [15:0] y,
                              logic signed [15:0] z);
        longint unsigned ax, ay, az, s;
        norm_result_t r;
        ax = (x < 0) ? -longint'(x) : longint'(x);
        ay = (y < 0) ? -longint'(y) : longint'(y);
        az = (z < 0) ? -longint'(z) : longint'(z);
        s = ax * ax + ay * ay + az * az;
        if (s == (64'd1 << 24)) begin
            r.x = signed_out(x, 16'(ax << 2));
            r.y = signed_out(y, 16'(ay << 2));
            r.z = signed_out(z, 16'(az << 2));
            r.status = svn_pkg::STATUS_UNIT;
        end else if (s == 0 || s < tolerance) begin
            r = '0;
            r.status = svn_pkg::STATUS_ZERO;
        end else begin
            r.x = signed_out(x, scaled_mag(ax, s));
            r.y = signed_out(y, scaled_mag(ay, s));
            r.z = signed_out(z, scaled_mag(az, s));
            r.status = svn_pkg::STATUS_NORM;
        end
        pending.push_back(r);
    endfunction

    task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    task check_result(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                      logic [1:0] status);
        norm_result_t e;
        if (pending.size() == 0) begin
            report_mismatch("unexpected beat", 16'(status), 16'(0));
            return;
        end
        e = pending.pop_front();
        if (x !== e.x) report_mismatch("x_out", x, e.x);
        if (y !== e.y) report_mismatch("y_out", y, e.y);
        if (z !== e.z) report_mismatch("z_out", z, e.z);
        if (status !== e.status) report_mismatch("status", 16'(status), 16'(e.status));
    endtask
endclass

module tb_safe_vector_normalize_3d;
    logic aclk, aresetn;
    logic psel, penable, pwrite;
    logic [svn_pkg::ADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic s_valid, s_ready, m_valid, m_ready;
    logic signed [15:0] s_x_in, s_y_in, s_z_in;
    logic signed [15:0] m_x_out, m_y_out, m_z_out;
    logic [1:0] m_status;
    int send_idle_pct, recv_stall_pct;
    norm_scoreboard board;

    safe_vector_normalize_3d DUT (.*);

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("Regression FAIL");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result(m_x_out, m_y_out, m_z_out, m_status);
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic write_tolerance(logic [31:0] value);
        @(negedge aclk);
        psel <= 1; pwrite <= 1; penable <= 0;
        paddr <= {svn_pkg::ADDR_IDX_TOLERANCE, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1;
        do @(posedge aclk); while (!pready);
        board.tolerance = value;
        @(negedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic send_vector(logic signed [15:0] x, logic signed [15:0] y,
                               logic signed [15:0] z);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(negedge aclk);
        end
        s_valid <= 1; s_x_in <= x; s_y_in <= y; s_z_in <= z;
        do @(posedge aclk); while (!s_ready);
        board.note_vector(x, y, z);
        @(negedge aclk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        s_valid <= 0;
        while (board.pending.size() != 0 && guard < 200000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (40) @(negedge aclk);
    endtask

    function automatic logic signed [15:0] rand_comp(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(8192)) - 4096);
            2: return 16'($signed($urandom_range(16)) - 8);
            default: return 16'($signed($urandom_range(2)) - 1) <<< 12;
        endcase
    endfunction

    task automatic random_phase(int count);
        int mode;
        repeat (count) begin
            mode = $urandom_range(3);
            send_vector(rand_comp(mode), rand_comp(mode), rand_comp(mode));
        end
    endtask

    initial begin
        board = new();
        aresetn = 0; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        s_valid = 0; s_x_in = 0; s_y_in = 0; s_z_in = 0; m_ready = 1;
        send_idle_pct = 0; recv_stall_pct = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        send_vector(0, 0, 0);
        send_vector(16'sh1000, 0, 0);
        send_vector(0, -16'sh1000, 0);
        send_vector(0, 0, 16'sh1000);
        send_vector(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_vector(-16'sh8000, -16'sh8000, -16'sh8000);
        send_vector(-16'sh8000, 16'sh7fff, 0);
        send_vector(1, 0, 0);
        send_vector(-1, -1, -1);
        send_vector(16'sh0800, 16'sh0800, 16'sh0800);
        send_vector(3, -4, 12);
        send_vector(16'sh5555, -16'sh2aab, 16'sh00ff);
        drain();

        write_tolerance(0);
        send_vector(0, 0, 0);
        send_vector(1, 0, 0);
        send_vector(0, -1, 1);
        drain();
        write_tolerance(32'hffffffff);
        send_vector(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_vector(-16'sh8000, -16'sh8000, 16'sh7fff);
        send_vector(16'sh1000, 0, 0);
        send_vector(16'sh4000, 0, 0);
        drain();
        write_tolerance(32'h01000000);
        send_vector(16'sh0fff, 0, 0);
        send_vector(0, 16'sh1000, 0);
        drain();

        for (int p = 0; p < 8; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            case (p)
                0: write_tolerance(svn_pkg::TOLERANCE_RESET);
                2: write_tolerance($urandom_range(32'h00100000));
                4: write_tolerance($urandom_range(32'h02000000));
                6: write_tolerance($urandom);
                default: ;
            endcase
            random_phase(210);
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
